[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("port check failed");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("port check failed");

`endif

[src/gbns_pkg.sv]
// ----------------------------------------------------------------------------
// gbns_pkg
// Types, direction codes and state encoding for the grid BFS step finder.
// ----------------------------------------------------------------------------
`default_nettype none

package gbns_pkg;

	// Width of the coordinate fields on the input port.
	localparam int COORD_W = 5;

	// Neighbor direction codes, tried in this order.
	typedef logic [1:0] dir_t;
	localparam dir_t DIR_XP = 2'd0;
	localparam dir_t DIR_XN = 2'd1;
	localparam dir_t DIR_YP = 2'd2;
	localparam dir_t DIR_YN = 2'd3;

	// One cell memory entry.
	typedef struct packed {
		logic wall;
		logic visited;
		dir_t parent;
	} cell_t;

	// Cell memory write command: wall field and search fields write separately.
	typedef struct packed {
		logic  wall_we;
		logic  mark_we;
		cell_t data;
	} cell_wr_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_START,
		ST_FETCH,
		ST_SCAN,
		ST_TRACE_RD,
		ST_TRACE,
		ST_CLEAN,
		ST_FINISH
	} gbns_state_t;

	// Column change of a direction.
	function automatic logic signed [1:0] dir_dx(input dir_t dir);
		logic signed [1:0] v;
		case (dir)
			DIR_XP:  v = 2'sb01;
			DIR_XN:  v = 2'sb11;
			default: v = 2'sb00;
		endcase
		return v;
	endfunction

	// Row change of a direction.
	function automatic logic signed [1:0] dir_dy(input dir_t dir);
		logic signed [1:0] v;
		case (dir)
			DIR_YP:  v = 2'sb01;
			DIR_YN:  v = 2'sb11;
			default: v = 2'sb00;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

[src/gbns_cell_mem.sv]
// ----------------------------------------------------------------------------
// gbns_cell_mem
// Per-cell memory: wall bit, visited bit and parent direction. One write
// port with separate field enables, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbns_cell_mem #(
	parameter int ADDR_W = 10
) (
	input  wire logic                clk,
	input  wire gbns_pkg::cell_wr_t  wr,
	input  wire logic [ADDR_W-1:0]   wr_addr,
	input  wire logic [ADDR_W-1:0]   rd_addr,
	output gbns_pkg::cell_t          rd_data
);

	localparam int CELLS = 1 << ADDR_W;

	gbns_pkg::cell_t mem_q [CELLS];
	gbns_pkg::cell_t rd_q;

	// Field-masked write, registered read
	always_ff @(posedge clk) begin
		if (wr.wall_we) begin
			mem_q[wr_addr].wall <= wr.data.wall;
		end
		if (wr.mark_we) begin
			mem_q[wr_addr].visited <= wr.data.visited;
			mem_q[wr_addr].parent  <= wr.data.parent;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[src/gbns_queue_mem.sv]
// ----------------------------------------------------------------------------
// gbns_queue_mem
// Frontier queue storage. One write and one read port; the read is
// registered and returns the data being written when the addresses match.
// ----------------------------------------------------------------------------
`default_nettype none

module gbns_queue_mem #(
	parameter int ADDR_W = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [ADDR_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [ADDR_W-1:0] rdata
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [ADDR_W-1:0] mem_q [DEPTH];
	logic [ADDR_W-1:0] rdata_q;

	// Write, read with write-first forwarding
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[src/grid_bfs_next_step_core.sv]
// ----------------------------------------------------------------------------
// grid_bfs_next_step_core
// Breadth-first path step finder over a tile grid with a one-bit wall map.
// ----------------------------------------------------------------------------
//  channel | signals                                  | dir | beat
//  in      | in_valid/in_ready, op row col wall goal_* | in  | wall write or query
//  out     | out_valid/out_ready, reachable step_dx/dy | out | one per query
//
//  Wall write: written from the input beat. Query with start or goal off the grid, or start
//  equal to goal: no search. Other queries: per dequeued cell one queue read plus four
//  cell-memory reads on the single read port, then one read per traced path step,
//  then a pass over the visited cells to clear their visited marks afterward.
//  After reset the visited bits of all 2**(ROW_W+COL_W) cells are swept
//  (1024 at 32x32) with in_ready low.
//  A finished result waits in the output register; a new item is taken while
//  it waits, and a query stalls at its end until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bfs_next_step_core #(
	parameter int GRID_ROWS = 32,
	parameter int GRID_COLS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          op,
	input  wire logic [gbns_pkg::COORD_W-1:0]  row,
	input  wire logic [gbns_pkg::COORD_W-1:0]  col,
	input  wire logic                          wall,
	input  wire logic [gbns_pkg::COORD_W-1:0]  goal_row,
	input  wire logic [gbns_pkg::COORD_W-1:0]  goal_col,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               reachable,
	output logic signed [1:0]                  step_dx,
	output logic signed [1:0]                  step_dy
);

	localparam int ROW_W  = $clog2(GRID_ROWS);
	localparam int COL_W  = $clog2(GRID_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int PTR_W  = ADDR_W + 1;
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
	localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);

	gbns_pkg::gbns_state_t state_q, state_d;

	logic [ADDR_W-1:0] start_q, goal_q, cur_q, trace_q, sweep_q;
	logic [PTR_W-1:0]  head_q, tail_q, clean_idx_q;
	gbns_pkg::dir_t    dir_q;
	logic              nbr_vld_s1;
	logic [ADDR_W-1:0] nbr_addr_s1;
	gbns_pkg::dir_t    nbr_dir_s1;
	logic              clean_pend_s1;
	logic              res_reach_q;
	logic signed [1:0] res_dx_q, res_dy_q;
	logic              out_valid_q, reachable_q;
	logic signed [1:0] step_dx_q, step_dy_q;

	// Memory ports
	gbns_pkg::cell_wr_t cell_wr;
	logic [ADDR_W-1:0]  cell_waddr, cell_raddr;
	gbns_pkg::cell_t    cell_rd;
	logic               q_we;
	logic [ADDR_W-1:0]  q_waddr, q_wdata, q_raddr, q_rdata;

	// Combinational helpers
	logic              acc_in;
	logic              start_ok, goal_ok;
	logic [ADDR_W-1:0] in_start, in_goal;
	logic [ADDR_W-1:0] scan_cell, nb_addr;
	logic              nb_ok;
	logic              ev_en, ev_take, ev_found;
	logic [PTR_W-1:0]  tail_nxt;
	logic              more;
	logic [ADDR_W-1:0] tr_addr;
	logic              tr_ok, tr_hit;
	logic              clean_issue, finish_go;

	gbns_cell_mem #(.ADDR_W(ADDR_W)) u_cell (
		.clk     (clk),
		.wr      (cell_wr),
		.wr_addr (cell_waddr),
		.rd_addr (cell_raddr),
		.rd_data (cell_rd)
	);

	gbns_queue_mem #(.ADDR_W(ADDR_W)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	// Input decode
	assign acc_in   = in_valid && in_ready;
	assign start_ok = (32'(row) < GRID_ROWS) && (32'(col) < GRID_COLS);
	assign goal_ok  = (32'(goal_row) < GRID_ROWS) && (32'(goal_col) < GRID_COLS);
	assign in_start = {ROW_W'(row), COL_W'(col)};
	assign in_goal  = {ROW_W'(goal_row), COL_W'(goal_col)};

	// Neighbor of the cell being scanned, in direction dir_q
	always_comb begin
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		scan_cell = (dir_q == gbns_pkg::DIR_XP) ? q_rdata : cur_q;
		r = scan_cell[ADDR_W-1:COL_W];
		c = scan_cell[COL_W-1:0];
		nb_ok = 1'b0;
		case (dir_q)
			gbns_pkg::DIR_XP: begin
				nb_ok = (c != COL_LAST);
				c = c + COL_W'(1);
			end
			gbns_pkg::DIR_XN: begin
				nb_ok = (c != '0);
				c = c - COL_W'(1);
			end
			gbns_pkg::DIR_YP: begin
				nb_ok = (r != ROW_LAST);
				r = r + ROW_W'(1);
			end
			gbns_pkg::DIR_YN: begin
				nb_ok = (r != '0);
				r = r - ROW_W'(1);
			end
			default: nb_ok = 1'b0;
		endcase
		nb_addr = {r, c};
	end

	// Neighbor evaluation in the cycle after its read
	assign ev_en    = nbr_vld_s1
		&& ((state_q == gbns_pkg::ST_SCAN) || (state_q == gbns_pkg::ST_FETCH));
	assign ev_take  = ev_en && !cell_rd.visited && !cell_rd.wall;
	assign ev_found = ev_take && (nbr_addr_s1 == goal_q);
	assign tail_nxt = tail_q + PTR_W'(ev_take);
	assign more     = (head_q < tail_nxt);

	// Parent of the cell being traced back
	always_comb begin
		logic [ROW_W-1:0] r;
		logic [COL_W-1:0] c;
		r = trace_q[ADDR_W-1:COL_W];
		c = trace_q[COL_W-1:0];
		tr_ok = 1'b0;
		case (cell_rd.parent)
			gbns_pkg::DIR_XP: begin
				tr_ok = (c != '0);
				c = c - COL_W'(1);
			end
			gbns_pkg::DIR_XN: begin
				tr_ok = (c != COL_LAST);
				c = c + COL_W'(1);
			end
			gbns_pkg::DIR_YP: begin
				tr_ok = (r != '0);
				r = r - ROW_W'(1);
			end
			gbns_pkg::DIR_YN: begin
				tr_ok = (r != ROW_LAST);
				r = r + ROW_W'(1);
			end
			default: tr_ok = 1'b0;
		endcase
		tr_addr = {r, c};
		tr_hit  = (tr_addr == start_q);
	end

	assign clean_issue = (clean_idx_q != tail_q);
	assign finish_go   = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gbns_pkg::ST_SWEEP: begin
				if (&sweep_q) state_d = gbns_pkg::ST_IDLE;
			end
			gbns_pkg::ST_IDLE: begin
				if (acc_in && op) begin
					if (!start_ok || !goal_ok || (in_start == in_goal)) begin
						state_d = gbns_pkg::ST_FINISH;
					end else begin
						state_d = gbns_pkg::ST_START;
					end
				end
			end
			gbns_pkg::ST_START: state_d = gbns_pkg::ST_FETCH;
			gbns_pkg::ST_FETCH: begin
				if (ev_found)  state_d = gbns_pkg::ST_TRACE_RD;
				else if (more) state_d = gbns_pkg::ST_SCAN;
				else           state_d = gbns_pkg::ST_CLEAN;
			end
			gbns_pkg::ST_SCAN: begin
				if (ev_found)                        state_d = gbns_pkg::ST_TRACE_RD;
				else if (dir_q == gbns_pkg::DIR_YN)  state_d = gbns_pkg::ST_FETCH;
			end
			gbns_pkg::ST_TRACE_RD: state_d = gbns_pkg::ST_TRACE;
			gbns_pkg::ST_TRACE: begin
				if (!tr_ok || tr_hit) state_d = gbns_pkg::ST_CLEAN;
			end
			gbns_pkg::ST_CLEAN: begin
				if (!clean_issue && !clean_pend_s1) state_d = gbns_pkg::ST_FINISH;
			end
			gbns_pkg::ST_FINISH: begin
				if (finish_go) state_d = gbns_pkg::ST_IDLE;
			end
			default: state_d = gbns_pkg::ST_SWEEP;
		endcase
	end

	// Memory controls
	always_comb begin
		cell_wr    = '0;
		cell_waddr = nbr_addr_s1;
		cell_raddr = nb_addr;
		q_we       = 1'b0;
		q_waddr    = tail_q[ADDR_W-1:0];
		q_wdata    = nbr_addr_s1;
		q_raddr    = head_q[ADDR_W-1:0];
		case (state_q)
			gbns_pkg::ST_SWEEP: begin
				cell_wr.mark_we = 1'b1;
				cell_waddr      = sweep_q;
			end
			gbns_pkg::ST_IDLE: begin
				cell_wr.wall_we   = acc_in && !op && start_ok;
				cell_wr.data.wall = wall;
				cell_waddr        = in_start;
			end
			gbns_pkg::ST_START: begin
				cell_wr.mark_we      = 1'b1;
				cell_wr.data.visited = 1'b1;
				cell_waddr           = start_q;
				q_we                 = 1'b1;
				q_waddr              = '0;
				q_wdata              = start_q;
			end
			gbns_pkg::ST_FETCH, gbns_pkg::ST_SCAN: begin
				cell_wr.mark_we      = ev_take;
				cell_wr.data.visited = 1'b1;
				cell_wr.data.parent  = nbr_dir_s1;
				q_we                 = ev_take;
			end
			gbns_pkg::ST_TRACE_RD: cell_raddr = goal_q;
			gbns_pkg::ST_TRACE:    cell_raddr = tr_addr;
			gbns_pkg::ST_CLEAN: begin
				q_raddr         = clean_idx_q[ADDR_W-1:0];
				cell_wr.mark_we = clean_pend_s1;
				cell_waddr      = q_rdata;
			end
			default: ;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= gbns_pkg::ST_SWEEP;
		else         state_q <= state_d;
	end

	// Search control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q       <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			clean_idx_q   <= '0;
			dir_q         <= gbns_pkg::DIR_XP;
			nbr_vld_s1    <= 1'b0;
			clean_pend_s1 <= 1'b0;
		end else begin
			nbr_vld_s1    <= (state_q == gbns_pkg::ST_SCAN) && nb_ok && !ev_found;
			clean_pend_s1 <= (state_q == gbns_pkg::ST_CLEAN) && clean_issue;
			case (state_q)
				gbns_pkg::ST_SWEEP: sweep_q <= sweep_q + ADDR_W'(1);
				gbns_pkg::ST_START: begin
					head_q      <= '0;
					tail_q      <= PTR_W'(1);
					clean_idx_q <= '0;
				end
				gbns_pkg::ST_FETCH: begin
					tail_q <= tail_nxt;
					dir_q  <= gbns_pkg::DIR_XP;
					if (more) head_q <= head_q + PTR_W'(1);
				end
				gbns_pkg::ST_SCAN: begin
					tail_q <= tail_nxt;
					dir_q  <= dir_q + 2'd1;
				end
				gbns_pkg::ST_CLEAN: begin
					if (clean_issue) clean_idx_q <= clean_idx_q + PTR_W'(1);
				end
				default: ;
			endcase
		end
	end

	// Search datapath registers
	always_ff @(posedge clk) begin
		if (state_q == gbns_pkg::ST_SCAN) begin
			nbr_addr_s1 <= nb_addr;
			nbr_dir_s1  <= dir_q;
			if (dir_q == gbns_pkg::DIR_XP) cur_q <= q_rdata;
		end
		case (state_q)
			gbns_pkg::ST_IDLE: begin
				start_q     <= in_start;
				goal_q      <= in_goal;
				res_reach_q <= start_ok && goal_ok && (in_start == in_goal);
				res_dx_q    <= 2'sb00;
				res_dy_q    <= 2'sb00;
			end
			gbns_pkg::ST_FETCH: begin
				if (!ev_found && !more) res_reach_q <= 1'b0;
			end
			gbns_pkg::ST_TRACE_RD: trace_q <= goal_q;
			gbns_pkg::ST_TRACE: begin
				trace_q <= tr_addr;
				if (!tr_ok) begin
					res_reach_q <= 1'b0;
				end else if (tr_hit) begin
					res_reach_q <= 1'b1;
					res_dx_q    <= gbns_pkg::dir_dx(cell_rd.parent);
					res_dy_q    <= gbns_pkg::dir_dy(cell_rd.parent);
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == gbns_pkg::ST_FINISH) && finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == gbns_pkg::ST_FINISH) && finish_go) begin
			reachable_q <= res_reach_q;
			step_dx_q   <= res_dx_q;
			step_dy_q   <= res_dy_q;
		end
	end

	assign in_ready  = (state_q == gbns_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign reachable = reachable_q;
	assign step_dx   = step_dx_q;
	assign step_dy   = step_dy_q;

endmodule

`default_nettype wire

[src/gbns_checker.sv]
// ----------------------------------------------------------------------------
// gbns_checker
// Port-level checks on the grid BFS step finder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gbns_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          op,
	input wire logic [gbns_pkg::COORD_W-1:0]  row,
	input wire logic [gbns_pkg::COORD_W-1:0]  col,
	input wire logic                          wall,
	input wire logic [gbns_pkg::COORD_W-1:0]  goal_row,
	input wire logic [gbns_pkg::COORD_W-1:0]  goal_col,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic                          reachable,
	input wire logic signed [1:0]             step_dx,
	input wire logic signed [1:0]             step_dy
);

	// Output beat holds while stalled
	`ASSERT_NXT(a_out_hold, clk, arst_n, (out_valid && !out_ready), (out_valid && $stable({reachable, step_dx, step_dy})))

	// An accepted query leaves the block busy, with in_ready low
	`ASSERT_NXT(a_query_busy, clk, arst_n, (in_valid && in_ready && op), (!in_ready))

	// Unreachable result carries no step
	`ASSERT_IMP(a_unreach_zero, clk, arst_n, (out_valid && !reachable), ((step_dx == 2'sb00) && (step_dy == 2'sb00)))

	// A reachable step moves along one axis by at most one cell
	`ASSERT_IMP(a_step_shape, clk, arst_n, (out_valid && reachable), (((step_dx == 2'sb00) || (step_dy == 2'sb00)) && (step_dx != 2'sb10) && (step_dy != 2'sb10)))

endmodule

bind grid_bfs_next_step_core gbns_checker u_gbns_checker (.*);

`default_nettype wire

[tb/sv/grid_bfs_next_step_core_tb.sv]
// ----------------------------------------------------------------------------
// grid_bfs_next_step_core_tb
// Self-checking bench for the grid BFS step finder. Writes two walled-off
// regions (one in each far corner), runs directed path queries (corners, every
// first-step direction, walls on start and goal, enclosed cells), a long
// output hold, then random mazes of two densities. Searches only start inside
// the written regions. Each query beat is predicted by a local BFS.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_bfs_next_step_core_tb;

	localparam int ROWS          = 32;
	localparam int COLS          = 32;
	localparam int CELLS         = ROWS * COLS;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 40000;
	localparam int SETTLE_CYCLES = 50;

	// Region A: top-left square, ring of walls just past it
	localparam int A_SIZE = 6;
	// Region B: bottom-right square, ring of walls just before it
	localparam int B_SIZE = 4;
	localparam int B_LO   = ROWS - B_SIZE;

	// Input op codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              reachable;
		logic signed [1:0] dx;
		logic signed [1:0] dy;
	} step_t;

	logic                          clk      = 1'b0;
	logic                          arst_n   = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic                          op       = OP_WRITE;
	logic [gbns_pkg::COORD_W-1:0]  row      = '0;
	logic [gbns_pkg::COORD_W-1:0]  col      = '0;
	logic                          wall     = 1'b0;
	logic [gbns_pkg::COORD_W-1:0]  goal_row = '0;
	logic [gbns_pkg::COORD_W-1:0]  goal_col = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          reachable;
	logic signed [1:0]             step_dx;
	logic signed [1:0]             step_dy;

	// Shadow wall map and pending first-step predictions
	bit    wall_shadow [CELLS];
	step_t step_expected [$];

	int fail_count   = 0;
	int write_count  = 0;
	int query_count  = 0;
	int reach_count  = 0;
	int quiet_cycles = 0;

	// Traffic shaping shared between the sender and the receiver
	logic steady      = 1'b0;
	int   hold_req    = 0;
	int   hold_seen   = 0;
	int   hold_left   = 0;

	grid_bfs_next_step_core #(
		.GRID_ROWS(ROWS),
		.GRID_COLS(COLS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.row       (row),
		.col       (col),
		.wall      (wall),
		.goal_row  (goal_row),
		.goal_col  (goal_col),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.reachable (reachable),
		.step_dx   (step_dx),
		.step_dy   (step_dy)
	);

	// Clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Neighbor offsets per direction code
	function automatic int col_shift(input gbns_pkg::dir_t d);
		case (d)
			gbns_pkg::DIR_XP: return 1;
			gbns_pkg::DIR_XN: return -1;
			default:          return 0;
		endcase
	endfunction

	function automatic int row_shift(input gbns_pkg::dir_t d);
		case (d)
			gbns_pkg::DIR_YP: return 1;
			gbns_pkg::DIR_YN: return -1;
			default:          return 0;
		endcase
	endfunction

	// BFS from start to goal over the shadow map, then walk the parent links
	// back to find the first move.
	function automatic step_t bfs_first_step(input int sr, input int sc, input int gr,
		input int gc);
		bit             seen [CELLS];
		gbns_pkg::dir_t came_from [CELLS];
		int             frontier [CELLS];
		int             head, tail, start, goal, cur, cr, cc, nr, nc, nxt, pr, pc, k, hops;
		gbns_pkg::dir_t d;
		bit             hit;
		step_t          res;
		res = '0;
		if (sr >= ROWS || sc >= COLS || gr >= ROWS || gc >= COLS)
			return res;
		start = sr * COLS + sc;
		goal  = gr * COLS + gc;
		if (start == goal) begin
			res.reachable = 1'b1;
			return res;
		end
		foreach (seen[i])
			seen[i] = 1'b0;
		head = 0;
		tail = 1;
		frontier[0] = start;
		seen[start] = 1'b1;
		hit = 1'b0;
		while (head < tail && !hit) begin
			cur = frontier[head];
			head++;
			cr = cur / COLS;
			cc = cur % COLS;
			for (k = 0; k < 4 && !hit; k++) begin
				d = gbns_pkg::dir_t'(k);
				nr = cr + row_shift(d);
				nc = cc + col_shift(d);
				if (nr >= 0 && nr < ROWS && nc >= 0 && nc < COLS) begin
					nxt = nr * COLS + nc;
					if (!seen[nxt] && !wall_shadow[nxt]) begin
						frontier[tail] = nxt;
						tail++;
						seen[nxt] = 1'b1;
						came_from[nxt] = d;
						if (nxt == goal)
							hit = 1'b1;
					end
				end
			end
		end
		if (!seen[goal])
			return res;
		cur = goal;
		for (hops = 0; hops < CELLS; hops++) begin
			d  = came_from[cur];
			pr = cur / COLS - row_shift(d);
			pc = cur % COLS - col_shift(d);
			if (pr < 0 || pr >= ROWS || pc < 0 || pc >= COLS)
				break;
			if (pr * COLS + pc == start) begin
				res.reachable = 1'b1;
				res.dx = 2'(col_shift(d));
				res.dy = 2'(row_shift(d));
				return res;
			end
			cur = pr * COLS + pc;
		end
		return res;
	endfunction

	function automatic int clamp_coord(input int v, input int hi);
		if (v < 0)
			return 0;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// Random cell inside one of the two written regions
	function automatic void pick_cell(output int r, output int c);
		if ($urandom_range(1) == 0) begin
			r = int'($urandom_range(A_SIZE - 1));
			c = int'($urandom_range(A_SIZE - 1));
		end else begin
			r = B_LO + int'($urandom_range(B_SIZE - 1));
			c = B_LO + int'($urandom_range(B_SIZE - 1));
		end
	endfunction

	// Input side: update shadow map on writes, predict on queries
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (op == OP_QUERY) begin
				step_expected.push_back(bfs_first_step(row, col, goal_row, goal_col));
				query_count++;
			end else begin
				if (row < ROWS && col < COLS)
					wall_shadow[row * COLS + col] = wall;
				write_count++;
			end
		end
	end

	// Output side: compare each result beat with the oldest prediction
	always @(posedge clk) begin
		step_t want;
		if (arst_n && out_valid && out_ready) begin
			if (reachable === 1'b1)
				reach_count++;
			if (step_expected.size() == 0) begin
				$display("%0t: result beat with nothing pending (reachable %0d dx %0d dy %0d)",
					$time, reachable, step_dx, step_dy);
				fail_count++;
			end else begin
				want = step_expected.pop_front();
				if (reachable !== want.reachable) begin
					$display("%0t: reachable expected %0d actual %0d",
						$time, want.reachable, reachable);
					fail_count++;
				end
				if (step_dx !== want.dx) begin
					$display("%0t: step_dx expected %0d actual %0d", $time, want.dx, step_dx);
					fail_count++;
				end
				if (step_dy !== want.dy) begin
					$display("%0t: step_dy expected %0d actual %0d", $time, want.dy, step_dy);
					fail_count++;
				end
			end
		end
	end

	// Receiver: random stalls, idle-free stretches, and a long hold on request
	always @(posedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (steady) begin
			out_ready <= 1'b1;
		end else begin
			out_ready <= ($urandom_range(99) >= 35);
		end
	end

	// Watchdog: ends the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no beat moved in %0d cycles, %0d results pending",
				$time, QUIET_LIMIT, step_expected.size());
			$display("FAIL");
			$finish;
		end
	end

	// Present one input beat and hold it until taken
	task automatic offer_beat(input logic o, input logic [gbns_pkg::COORD_W-1:0] r,
		input logic [gbns_pkg::COORD_W-1:0] c, input logic w,
		input logic [gbns_pkg::COORD_W-1:0] gr, input logic [gbns_pkg::COORD_W-1:0] gc);
		if (!steady && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		row      <= r;
		col      <= c;
		wall     <= w;
		goal_row <= gr;
		goal_col <= gc;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic write_cell(input int r, input int c, input logic w);
		offer_beat(OP_WRITE, gbns_pkg::COORD_W'(r), gbns_pkg::COORD_W'(c), w,
			gbns_pkg::COORD_W'($urandom_range(ROWS - 1)),
			gbns_pkg::COORD_W'($urandom_range(COLS - 1)));
	endtask

	task automatic query_path(input int sr, input int sc, input int gr, input int gc);
		offer_beat(OP_QUERY, gbns_pkg::COORD_W'(sr), gbns_pkg::COORD_W'(sc),
			1'($urandom_range(1)), gbns_pkg::COORD_W'(gr), gbns_pkg::COORD_W'(gc));
	endtask

	// Write both regions (walls at the given percentage) and their wall rings
	task automatic fill_regions(input int wall_pct);
		int r, c, k;
		for (r = 0; r < A_SIZE; r++)
			for (c = 0; c < A_SIZE; c++)
				write_cell(r, c, $urandom_range(99) < wall_pct);
		for (r = B_LO; r < ROWS; r++)
			for (c = B_LO; c < COLS; c++)
				write_cell(r, c, $urandom_range(99) < wall_pct);
		for (k = 0; k < A_SIZE; k++) begin
			write_cell(A_SIZE, k, 1'b1);
			write_cell(k, A_SIZE, 1'b1);
		end
		for (k = 0; k < B_SIZE; k++) begin
			write_cell(B_LO - 1, B_LO + k, 1'b1);
			write_cell(B_LO + k, B_LO - 1, 1'b1);
		end
	endtask

	task automatic test_fill_open();
		steady <= 1'b1;
		fill_regions(0);
		steady <= 1'b0;
	endtask

	// Corners, each first-step direction, walls on start and goal, enclosed cells
	task automatic test_directed_paths();
		query_path(0, 0, 0, 0);
		query_path(ROWS - 1, COLS - 1, ROWS - 1, COLS - 1);
		query_path(0, 0, A_SIZE - 1, A_SIZE - 1);
		query_path(ROWS - 1, COLS - 1, B_LO, B_LO);
		query_path(0, 0, ROWS - 1, COLS - 1);
		query_path(B_LO, B_LO, 0, 0);
		query_path(2, 2, 2, 3);
		query_path(2, 2, 2, 1);
		query_path(2, 2, 3, 2);
		query_path(2, 2, 1, 2);
		write_cell(3, 3, 1'b1);
		query_path(3, 2, 3, 3);
		query_path(3, 3, 3, 5);
		write_cell(0, 4, 1'b1);
		write_cell(2, 4, 1'b1);
		write_cell(1, 3, 1'b1);
		write_cell(1, 5, 1'b1);
		query_path(0, 0, 1, 4);
		query_path(1, 4, 0, 0);
		write_cell(3, 3, 1'b0);
		query_path(3, 2, 3, 3);
	endtask

	// Receiver holds off while short queries keep coming, so input backs up
	task automatic test_output_hold();
		int k, sr, sc;
		hold_req <= hold_req + 1;
		for (k = 0; k < 12; k++) begin
			pick_cell(sr, sc);
			if (k % 3 == 2)
				query_path(sr, sc, clamp_coord(sr + 1, ROWS - 1), sc);
			else
				query_path(sr, sc, sr, sc);
		end
	endtask

	// Random walls inside the regions mixed with near/far queries
	task automatic test_random_maze(input int wall_pct, input int n_items, input int steady_items);
		int k, sr, sc, gr, gc;
		for (k = 0; k < n_items; k++) begin
			steady <= (k < steady_items);
			if ($urandom_range(99) < 40) begin
				pick_cell(sr, sc);
				write_cell(sr, sc, $urandom_range(99) < wall_pct);
			end else begin
				pick_cell(sr, sc);
				if ($urandom_range(1)) begin
					gr = clamp_coord(sr + int'($urandom_range(6)) - 3, ROWS - 1);
					gc = clamp_coord(sc + int'($urandom_range(6)) - 3, COLS - 1);
				end else begin
					gr = int'($urandom_range(ROWS - 1));
					gc = int'($urandom_range(COLS - 1));
				end
				query_path(sr, sc, gr, gc);
			end
		end
		steady <= 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_open();
		test_directed_paths();
		test_output_hold();
		test_random_maze(30, 18, 9);
		test_random_maze(55, 18, 0);
		in_valid <= 1'b0;
		while (step_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Run covered %0d cell writes and %0d path queries, %0d of them reachable,",
			write_count, query_count, reach_count);
		$display("in two walled corner regions, with a long output hold and idle-free stretches.");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/gbns_pkg.sv
src/gbns_cell_mem.sv
src/gbns_queue_mem.sv
src/grid_bfs_next_step_core.sv
src/gbns_checker.sv
tb/sv/grid_bfs_next_step_core_tb.sv
